FILE: design/mls_pkg.sv
// ----------------------------------------------------------------------------
// mls_pkg
// Shared command codes and result flag type for the midpoint line stepper.
// ----------------------------------------------------------------------------
package mls_pkg;

    // Command codes carried on the input channel
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Per-result status flags
    typedef struct packed {
        logic pixel_valid;
        logic last_pixel;
    } mls_flags_t;

endpackage

FILE: design/mls_setup.sv
// ----------------------------------------------------------------------------
// mls_setup
// Line setup: major axis, start endpoint, minor direction and decision terms.
// ----------------------------------------------------------------------------
module mls_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    output logic [COORD_BITS-1:0]        first_x,
    output logic [COORD_BITS-1:0]        first_y,
    output logic [COORD_BITS-1:0]        major_len,
    output logic [COORD_BITS:0]          inc_straight,
    output logic signed [COORD_BITS+1:0] inc_diagonal,
    output logic signed [COORD_BITS+2:0] decision_init,
    output logic                         minor_dir_negative,
    output logic                         major_is_y
);

    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] minor_len;
    logic                  swap;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;

    always_comb begin
        adx = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
        ady = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
        major_is_y = (ady > adx);

        // Start from the lower end of the major axis
        if (major_is_y) begin
            swap = (start_y > end_y);
        end else begin
            swap = (start_x > end_x);
        end
        first_x = swap ? end_x : start_x;
        first_y = swap ? end_y : start_y;
        last_x  = swap ? start_x : end_x;
        last_y  = swap ? start_y : end_y;

        if (major_is_y) begin
            minor_dir_negative = (last_x < first_x);
            major_len = ady;
            minor_len = adx;
        end else begin
            minor_dir_negative = (last_y < first_y);
            major_len = adx;
            minor_len = ady;
        end

        inc_straight  = {minor_len, 1'b0};
        inc_diagonal  = $signed({1'b0, minor_len, 1'b0}) - $signed({1'b0, major_len, 1'b0});
        decision_init = $signed({2'b00, minor_len, 1'b0}) - $signed({3'b000, major_len});
    end

endmodule

FILE: design/mls_core.sv
// ----------------------------------------------------------------------------
// mls_core
// Line state registers and the per-item load or step update.
// ----------------------------------------------------------------------------
module mls_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         fire,
    input  logic                         cmd,
    input  logic [COORD_BITS-1:0]        first_x,
    input  logic [COORD_BITS-1:0]        first_y,
    input  logic [COORD_BITS-1:0]        major_len,
    input  logic [COORD_BITS:0]          inc_straight,
    input  logic signed [COORD_BITS+1:0] inc_diagonal,
    input  logic signed [COORD_BITS+2:0] decision_init,
    input  logic                         minor_dir_negative,
    input  logic                         major_is_y,
    output logic [COORD_BITS-1:0]        res_x,
    output logic [COORD_BITS-1:0]        res_y,
    output mls_pkg::mls_flags_t          res_flags
);

    logic [COORD_BITS-1:0]        cur_x_reg,        cur_x_next;
    logic [COORD_BITS-1:0]        cur_y_reg,        cur_y_next;
    logic [COORD_BITS-1:0]        steps_left_reg,   steps_left_next;
    logic signed [COORD_BITS+2:0] decision_reg,     decision_next;
    logic [COORD_BITS:0]          inc_straight_reg, inc_straight_next;
    logic signed [COORD_BITS+1:0] inc_diagonal_reg, inc_diagonal_next;
    logic                         minor_neg_reg,    minor_neg_next;
    logic                         major_y_reg,      major_y_next;
    logic                         active_reg,       active_next;

    logic                  diag;
    logic [COORD_BITS-1:0] major_cur;
    logic [COORD_BITS-1:0] minor_cur;
    logic [COORD_BITS-1:0] major_new;
    logic [COORD_BITS-1:0] minor_new;

    always_comb begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        steps_left_next   = steps_left_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        minor_neg_next    = minor_neg_reg;
        major_y_next      = major_y_reg;
        active_next       = active_reg;

        diag      = !decision_reg[COORD_BITS+2] && (decision_reg != '0);
        major_cur = major_y_reg ? cur_y_reg : cur_x_reg;
        minor_cur = major_y_reg ? cur_x_reg : cur_y_reg;
        major_new = major_cur + COORD_BITS'(1);
        if (!diag) begin
            minor_new = minor_cur;
        end else if (minor_neg_reg) begin
            minor_new = minor_cur - COORD_BITS'(1);
        end else begin
            minor_new = minor_cur + COORD_BITS'(1);
        end

        res_x     = '0;
        res_y     = '0;
        res_flags = '0;

        if (cmd == mls_pkg::CMD_LOAD) begin
            cur_x_next        = first_x;
            cur_y_next        = first_y;
            steps_left_next   = major_len;
            decision_next     = decision_init;
            inc_straight_next = inc_straight;
            inc_diagonal_next = inc_diagonal;
            minor_neg_next    = minor_dir_negative;
            major_y_next      = major_is_y;
            active_next       = (major_len != '0);
            res_x                 = first_x;
            res_y                 = first_y;
            res_flags.pixel_valid = 1'b1;
            res_flags.last_pixel  = (major_len == '0);
        end else if (active_reg) begin
            cur_x_next      = major_y_reg ? minor_new : major_new;
            cur_y_next      = major_y_reg ? major_new : minor_new;
            steps_left_next = steps_left_reg - COORD_BITS'(1);
            if (diag) begin
                decision_next = decision_reg + (COORD_BITS+3)'(inc_diagonal_reg);
            end else begin
                decision_next = decision_reg + $signed({2'b00, inc_straight_reg});
            end
            active_next           = (steps_left_next != '0);
            res_x                 = cur_x_next;
            res_y                 = cur_y_next;
            res_flags.pixel_valid = 1'b1;
            res_flags.last_pixel  = (steps_left_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            steps_left_reg   <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            minor_neg_reg    <= 1'b0;
            major_y_reg      <= 1'b0;
            active_reg       <= 1'b0;
        end else if (fire) begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            steps_left_reg   <= steps_left_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            minor_neg_reg    <= minor_neg_next;
            major_y_reg      <= major_y_next;
            active_reg       <= active_next;
        end
    end

endmodule

FILE: design/midpoint_line_stepper.sv
// ----------------------------------------------------------------------------
// midpoint_line_stepper
// Path: an input transfer goes to the input register, its result to the result
// register on m_. Throughput: one item per cycle unless m_ready stalls; a
// pixel's line state update is the single pass between the two registers.
// Reset: aresetn low empties both registers and clears the line (no line).
// ----------------------------------------------------------------------------
module midpoint_line_stepper #(
    parameter int COORD_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [COORD_BITS-1:0] s_start_x,
    input  logic [COORD_BITS-1:0] s_start_y,
    input  logic [COORD_BITS-1:0] s_end_x,
    input  logic [COORD_BITS-1:0] s_end_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic                  m_pixel_valid,
    output logic                  m_last_pixel
);

    logic                  in_valid_reg, in_valid_next;
    logic                  cmd_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;

    logic                  res_valid_reg, res_valid_next;
    logic [COORD_BITS-1:0] res_x_reg;
    logic [COORD_BITS-1:0] res_y_reg;
    mls_pkg::mls_flags_t   res_flags_reg;

    logic                         advance;
    logic                         fire;
    logic                         in_xfer;
    logic [COORD_BITS-1:0]        first_x;
    logic [COORD_BITS-1:0]        first_y;
    logic [COORD_BITS-1:0]        major_len;
    logic [COORD_BITS:0]          inc_straight;
    logic signed [COORD_BITS+1:0] inc_diagonal;
    logic signed [COORD_BITS+2:0] decision_init;
    logic                         minor_dir_negative;
    logic                         major_is_y;
    logic [COORD_BITS-1:0]        res_x;
    logic [COORD_BITS-1:0]        res_y;
    mls_pkg::mls_flags_t          res_flags;

    assign advance = !res_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        res_valid_next = res_valid_reg;
        if (fire) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end
    end

    mls_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .start_x            (start_x_reg),
        .start_y            (start_y_reg),
        .end_x              (end_x_reg),
        .end_y              (end_y_reg),
        .first_x            (first_x),
        .first_y            (first_y),
        .major_len          (major_len),
        .inc_straight       (inc_straight),
        .inc_diagonal       (inc_diagonal),
        .decision_init      (decision_init),
        .minor_dir_negative (minor_dir_negative),
        .major_is_y         (major_is_y)
    );

    mls_core #(.COORD_BITS(COORD_BITS)) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .fire               (fire),
        .cmd                (cmd_reg),
        .first_x            (first_x),
        .first_y            (first_y),
        .major_len          (major_len),
        .inc_straight       (inc_straight),
        .inc_diagonal       (inc_diagonal),
        .decision_init      (decision_init),
        .minor_dir_negative (minor_dir_negative),
        .major_is_y         (major_is_y),
        .res_x              (res_x),
        .res_y              (res_y),
        .res_flags          (res_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg     <= s_cmd;
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
            end_x_reg   <= s_end_x;
            end_y_reg   <= s_end_y;
        end
        if (fire) begin
            res_x_reg     <= res_x;
            res_y_reg     <= res_y;
            res_flags_reg <= res_flags;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_pixel_x     = res_x_reg;
    assign m_pixel_y     = res_y_reg;
    assign m_pixel_valid = res_flags_reg.pixel_valid;
    assign m_last_pixel  = res_flags_reg.last_pixel;

endmodule

FILE: design/mls_checker.sv
// ----------------------------------------------------------------------------
// mls_checker
// Port-level checks on the midpoint line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module mls_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  s_cmd,
    input logic [COORD_BITS-1:0] s_start_x,
    input logic [COORD_BITS-1:0] s_start_y,
    input logic [COORD_BITS-1:0] s_end_x,
    input logic [COORD_BITS-1:0] s_end_y,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COORD_BITS-1:0] m_pixel_x,
    input logic [COORD_BITS-1:0] m_pixel_y,
    input logic                  m_pixel_valid,
    input logic                  m_last_pixel
);

    // A stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cmd) && $stable(s_start_x)
            && $stable(s_start_y) && $stable(s_end_x) && $stable(s_end_y))
        else $error("stalled input changed");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_pixel_valid) && $stable(m_last_pixel))
        else $error("stalled result changed");

    // An empty result stage never back-pressures the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

    // Advance with no line gives an all-zero result
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pixel_valid |-> m_pixel_x == '0 && m_pixel_y == '0 && !m_last_pixel)
        else $error("invalid pixel carries data");

    // Reset empties the result stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind midpoint_line_stepper mls_checker #(.COORD_BITS(COORD_BITS)) u_mls_checker (.*);

FILE: tb/sv/midpoint_line_stepper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_stepper_test
// Self-checking bench for the midpoint line stepper. A directed table covers
// the corner lines. Random lines follow: mostly complete load/advance runs
// with random content, plus stray advances and lines cut short by a reload.
// Each transfer goes through a line predictor, and every result is checked
// in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module midpoint_line_stepper_test;

    localparam int CB            = 10;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 800;
    localparam int STEADY_TAIL   = 100;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    typedef logic [CB-1:0] coord_t;

    typedef struct packed {
        coord_t              x;
        coord_t              y;
        mls_pkg::mls_flags_t flags;
    } pixel_t;

    typedef struct packed {
        logic   cmd;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   known;
        pixel_t pix;
    } row_t;

    logic   aclk    = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    logic   s_cmd   = mls_pkg::CMD_LOAD;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_end_x   = '0;
    coord_t s_end_y   = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    coord_t m_pixel_x;
    coord_t m_pixel_y;
    logic   m_pixel_valid;
    logic   m_last_pixel;

    // Typed-in expectation travelling with the payload on directed rows
    logic   row_known = 1'b0;
    pixel_t row_pix   = '0;

    row_t   script [DIRECTED_ROWS];
    pixel_t pending_pixels [$];
    int     fail_count = 0;
    int     sent_count = 0;
    int     gap_odds   = 0;
    int     stall_left = 0;
    bit     steady     = 1'b0;
    bit     ready_calm = 1'b0;

    // Line state of the predictor
    coord_t ln_x, ln_y, ln_left;
    int     ln_dec, ln_inc_str, ln_inc_diag;
    bit     ln_minor_neg, ln_major_y;
    bit     ln_active = 1'b0;

    midpoint_line_stepper #(.COORD_BITS(CB)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last_pixel  (m_last_pixel)
    );

    always #6 aclk = ~aclk;

    function automatic pixel_t next_pixel(input logic cmd, input coord_t sx, input coord_t sy,
                                          input coord_t ex, input coord_t ey);
        pixel_t p;
        int     adx, ady, dmaj, dmin;
        coord_t ax, ay, bx, by;
        logic   diag;
        p = '0;
        if (cmd == mls_pkg::CMD_LOAD) begin
            adx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
            ady = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
            ln_major_y = (ady > adx);
            // Start at the low end of the major axis
            if (ln_major_y) begin
                if (sy <= ey) {ax, ay, bx, by} = {sx, sy, ex, ey};
                else          {ax, ay, bx, by} = {ex, ey, sx, sy};
                ln_minor_neg = (bx < ax);
                dmaj = ady;
                dmin = adx;
            end else begin
                if (sx <= ex) {ax, ay, bx, by} = {sx, sy, ex, ey};
                else          {ax, ay, bx, by} = {ex, ey, sx, sy};
                ln_minor_neg = (by < ay);
                dmaj = adx;
                dmin = ady;
            end
            ln_x        = ax;
            ln_y        = ay;
            ln_left     = coord_t'(dmaj);
            ln_inc_str  = 2 * dmin;
            ln_inc_diag = 2 * (dmin - dmaj);
            ln_dec      = 2 * dmin - dmaj;
            ln_active   = 1'b1;
        end else if (ln_active) begin
            diag = (ln_dec > 0);
            if (ln_major_y) ln_y = ln_y + 1'b1;
            else            ln_x = ln_x + 1'b1;
            if (diag) begin
                ln_dec = ln_dec + ln_inc_diag;
                if (ln_major_y) ln_x = ln_minor_neg ? ln_x - 1'b1 : ln_x + 1'b1;
                else            ln_y = ln_minor_neg ? ln_y - 1'b1 : ln_y + 1'b1;
            end else begin
                ln_dec = ln_dec + ln_inc_str;
            end
            ln_left = ln_left - 1'b1;
        end
        // An advance with no line leaves an all-zero result
        if (cmd == mls_pkg::CMD_LOAD || ln_active) begin
            p.x                 = ln_x;
            p.y                 = ln_y;
            p.flags.pixel_valid = 1'b1;
            p.flags.last_pixel  = (ln_left == '0);
            if (ln_left == '0) ln_active = 1'b0;
        end
        return p;
    endfunction

    function automatic row_t mk_row(input logic cmd, input int sx, input int sy, input int ex,
                                    input int ey, input logic known, input int px, input int py,
                                    input logic pv, input logic pl);
        row_t r;
        r.cmd                   = cmd;
        r.sx                    = coord_t'(sx);
        r.sy                    = coord_t'(sy);
        r.ex                    = coord_t'(ex);
        r.ey                    = coord_t'(ey);
        r.known                 = known;
        r.pix.x                 = coord_t'(px);
        r.pix.y                 = coord_t'(py);
        r.pix.flags.pixel_valid = pv;
        r.pix.flags.last_pixel  = pl;
        return r;
    endfunction

    // Endpoint within span of c, kept inside the coordinate range
    function automatic coord_t near_coord(input coord_t c, input int span);
        int base, d, v;
        base = c;
        d    = $urandom_range(0, span);
        v    = base + d;
        if ($urandom_range(0, 1) == 1 || v > 1023) v = base - d;
        if (v < 0) v = base + d;
        return coord_t'(v);
    endfunction

    task automatic send_item(input logic cmd, input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey, input logic known,
                             input pixel_t pix);
        int gap;
        gap    = 0;
        steady = (sent_count >= DIRECTED_ROWS + RANDOM_ITEMS - STEADY_TAIL);
        if (!steady && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            gap = $urandom_range(1, 17);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_cmd     = cmd;
        s_start_x = sx;
        s_start_y = sy;
        s_end_x   = ex;
        s_end_y   = ey;
        row_known = known;
        row_pix   = pix;
        // Hold until the transfer happens
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic advance_once();
        send_item(mls_pkg::CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), 1'b0, '0);
    endtask

    // Result side: stall in bursts, with calm stretches and none at the tail
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            if (aresetn && !steady && !ready_calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 17);
        end
        if ($urandom_range(0, 149) == 0) ready_calm = !ready_calm;
    end

    always @(posedge aclk) begin : pixel_check
        pixel_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_pixel_x, m_pixel_y, m_pixel_valid, m_last_pixel};
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected pixel x=%0d y=%0d valid=%0b last=%0b",
                                 got.x, got.y, got.flags.pixel_valid, got.flags.last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.flags.pixel_valid !== want.flags.pixel_valid ||
                        got.flags.last_pixel !== want.flags.last_pixel) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch: want %0d,%0d v%0b l%0b got %0d,%0d v%0b l%0b",
                                     want.x, want.y, want.flags.pixel_valid,
                                     want.flags.last_pixel, got.x, got.y,
                                     got.flags.pixel_valid, got.flags.last_pixel);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = next_pixel(s_cmd, s_start_x, s_start_y, s_end_x, s_end_y);
                pending_pixels.push_back(row_known ? row_pix : want);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int     i, sel, span, dmaj, adx, ady;
        coord_t sx, sy, ex, ey;

        script[0]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
        script[1]  = mk_row(mls_pkg::CMD_LOAD, 1023, 1023, 1023, 1023, 1'b1,
                            1023, 1023, 1'b1, 1'b1);
        script[2]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
        script[3]  = mk_row(mls_pkg::CMD_LOAD, 0, 0, 1023, 0, 1'b1, 0, 0, 1'b1, 1'b0);
        script[4]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        // Reload over a live line, reversed horizontal
        script[5]  = mk_row(mls_pkg::CMD_LOAD, 1023, 1023, 0, 1023, 1'b1, 0, 1023, 1'b1, 1'b0);
        script[6]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        // Vertical, drawn upward from the smaller y
        script[7]  = mk_row(mls_pkg::CMD_LOAD, 5, 1023, 5, 1020, 1'b1, 5, 1020, 1'b1, 1'b0);
        script[8]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[9]  = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[10] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[11] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b1, 0, 0, 1'b0, 1'b0);
        // Diagonal with falling minor axis
        script[12] = mk_row(mls_pkg::CMD_LOAD, 10, 10, 7, 13, 1'b1, 7, 13, 1'b1, 1'b0);
        script[13] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[14] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[15] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        // Decision term starts at zero
        script[16] = mk_row(mls_pkg::CMD_LOAD, 0, 0, 2, 1, 1'b1, 0, 0, 1'b1, 1'b0);
        script[17] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[18] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[19] = mk_row(mls_pkg::CMD_LOAD, 3, 0, 0, 9, 1'b1, 3, 0, 1'b1, 1'b0);
        script[20] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[21] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[22] = mk_row(mls_pkg::CMD_LOAD, 0, 1023, 1023, 0, 1'b1, 0, 1023, 1'b1, 1'b0);
        script[23] = mk_row(mls_pkg::CMD_ADVANCE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 1'b0);
        script[24] = mk_row(mls_pkg::CMD_LOAD, 682, 682, 512, 341, 1'b1, 512, 341, 1'b1, 1'b0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        gap_odds = 3;
        for (i = 0; i < DIRECTED_ROWS; i++)
            send_item(script[i].cmd, script[i].sx, script[i].sy, script[i].ex, script[i].ey,
                      script[i].known, script[i].pix);

        while (sent_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 2;
                default: gap_odds = 6;
            endcase
            if (sel == 0) begin
                repeat ($urandom_range(1, 3)) advance_once();
            end else if (sel == 1) begin
                // Arbitrary endpoints, cut short by the next load
                send_item(mls_pkg::CMD_LOAD, coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), 1'b0, '0);
                repeat ($urandom_range(0, 30)) advance_once();
            end else begin
                if ($urandom_range(0, 3) == 0) span = 64;
                else span = ($urandom_range(0, 1) == 1) ? 16 : 3;
                sx = coord_t'($urandom);
                sy = coord_t'($urandom);
                ex = near_coord(sx, span);
                ey = near_coord(sy, span);
                adx = (ex >= sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
                ady = (ey >= sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
                dmaj = (adx > ady) ? adx : ady;
                send_item(mls_pkg::CMD_LOAD, sx, sy, ex, ey, 1'b0, '0);
                repeat (dmaj) advance_once();
                // Run past the end now and then
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) advance_once();
            end
        end
        s_valid = 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: midpoint_line_stepper.f
design/mls_pkg.sv
design/mls_setup.sv
design/mls_core.sv
design/midpoint_line_stepper.sv
design/mls_checker.sv
tb/sv/midpoint_line_stepper_test.sv
